/* rtl/chlcd_pkg.sv */
`default_nettype none
package chlcd_pkg;

  localparam int unsigned HoldW = 16;
  localparam int unsigned IdxW  = 3;
  localparam logic [HoldW-1:0] HoldReset = 16'd1000;

  localparam logic [1:0] OP_INIT = 2'd0;
  localparam logic [1:0] OP_CMD  = 2'd1;
  localparam logic [1:0] OP_DATA = 2'd2;

  localparam logic CFG_BUS_MODE = 1'b0;
  localparam logic CFG_HOLD     = 1'b1;

  localparam logic [7:0] CMD_WAKE           = 8'h30;
  localparam logic [7:0] CMD_HOME4          = 8'h02;
  localparam logic [7:0] CMD_FSET4          = 8'h28;
  localparam logic [7:0] CMD_FSET8          = 8'h38;
  localparam logic [7:0] CMD_CLEAR          = 8'h01;
  localparam logic [7:0] CMD_DISP_ON_CURSOR = 8'h0E;
  localparam logic [7:0] CMD_ENTRY_INC      = 8'h06;

  localparam logic [IdxW-1:0] InitLast4 = 3'd7;
  localparam logic [IdxW-1:0] InitLast8 = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRE,
    S_SNAP,
    S_WAIT
  } state_e;

  typedef struct packed {
    logic load;
    logic emit_pre;
    logic emit_snap;
    logic tick;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_one;
    logic hold_one;
    logic final_now;
    logic done;
  } dp_sts_t;

  // init command bytes after the first enable-high snapshot
  function automatic logic [7:0] init_cmd(input logic [IdxW-1:0] idx, input logic four);
    logic [7:0] b;
    b = CMD_ENTRY_INC;
    if (four) begin
      case (idx)
        3'd0, 3'd1, 3'd2: b = CMD_WAKE;
        3'd3:             b = CMD_HOME4;
        3'd4:             b = CMD_FSET4;
        3'd5:             b = CMD_CLEAR;
        3'd6:             b = CMD_DISP_ON_CURSOR;
        default:          b = CMD_ENTRY_INC;
      endcase
    end else begin
      case (idx)
        3'd0, 3'd1, 3'd2: b = CMD_WAKE;
        3'd3:             b = CMD_FSET8;
        3'd4:             b = CMD_CLEAR;
        3'd5:             b = CMD_DISP_ON_CURSOR;
        default:          b = CMD_ENTRY_INC;
      endcase
    end
    return b;
  endfunction

endpackage
`default_nettype wire

/* rtl/chlcd_ctrl.sv */
`default_nettype none
module chlcd_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [1:0]         opcode_i,
  input  wire chlcd_pkg::dp_sts_t sts_i,
  output chlcd_pkg::ctrl_cmd_t    cmd_o,
  output logic                    busy_o
);
  import chlcd_pkg::*;

  state_e state_q, state_d;
  logic   go;

  assign go = start_i && (state_q == S_IDLE) &&
              (opcode_i == OP_INIT || opcode_i == OP_CMD || opcode_i == OP_DATA);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (go) begin
          state_d = (opcode_i == OP_INIT) ? S_PRE : S_SNAP;
        end
      end
      S_PRE: begin
        state_d = sts_i.hold_one ? S_SNAP : S_WAIT;
      end
      S_SNAP: begin
        if (!sts_i.hold_one) begin
          state_d = S_WAIT;
        end else if (sts_i.final_now) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_SNAP;
        end
      end
      S_WAIT: begin
        if (sts_i.cnt_one) begin
          state_d = sts_i.done ? S_IDLE : S_SNAP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: cmd_o.load      = go;
      S_PRE:  cmd_o.emit_pre  = 1'b1;
      S_SNAP: cmd_o.emit_snap = 1'b1;
      S_WAIT: cmd_o.tick      = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

/* rtl/chlcd_dpath.sv */
`default_nettype none
module chlcd_dpath (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire chlcd_pkg::ctrl_cmd_t     cmd_i,
  input  wire logic [1:0]               opcode_i,
  input  wire logic [7:0]               byte_value_i,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_idx_i,
  input  wire logic [15:0]              cfg_wdata_i,
  output chlcd_pkg::dp_sts_t            sts_o,
  output logic                          snap_valid_o,
  output logic                          reg_select_o,
  output logic                          enable_pin_o,
  output logic [7:0]                    data_lines_o,
  output logic                          last_o
);
  import chlcd_pkg::*;

  logic             mode_q;
  logic [HoldW-1:0] hold_q;
  logic [HoldW-1:0] cnt_q, cnt_d;
  logic [HoldW-1:0] hold_m1;
  logic [1:0]       step_q, step_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             init_q, rs_q, done_q, done_d;
  logic [7:0]       byte_q;
  logic             valid_q, rso_q, en_q, last_q;
  logic [7:0]       data_q;
  logic [7:0]       cur_byte, nib, cur_data;
  logic             byte_last, init_last, final_now;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      hold_q <= HoldReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BUS_MODE: mode_q <= cfg_wdata_i[0];
        CFG_HOLD:     hold_q <= cfg_wdata_i;
        default:      mode_q <= mode_q;
      endcase
    end
  end

  assign hold_m1  = (hold_q == '0) ? '0 : hold_q - 1'b1;
  assign cur_byte = init_q ? init_cmd(idx_q, mode_q) : byte_q;
  assign nib      = step_q[1] ? {cur_byte[3:0], 4'h0} : {cur_byte[7:4], 4'h0};
  assign cur_data = mode_q ? nib : cur_byte;
  assign byte_last = mode_q ? (step_q == 2'd3) : (step_q == 2'd1);
  assign init_last = mode_q ? (idx_q == InitLast4) : (idx_q == InitLast8);
  assign final_now = byte_last && (!init_q || init_last);

  always_comb begin
    step_d = step_q;
    idx_d  = idx_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    if (cmd_i.load) begin
      step_d = '0;
      idx_d  = '0;
      done_d = 1'b0;
    end
    if (cmd_i.emit_snap) begin
      done_d = final_now;
      if (byte_last) begin
        step_d = '0;
        idx_d  = idx_q + 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
    if (cmd_i.emit_pre || cmd_i.emit_snap) begin
      cnt_d = hold_m1;
    end else if (cmd_i.tick) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      valid_q <= cmd_i.emit_pre || cmd_i.emit_snap;
    end
  end

  // request payload and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      init_q <= (opcode_i == OP_INIT);
      rs_q   <= (opcode_i == OP_DATA);
      byte_q <= byte_value_i;
    end
    if (cmd_i.emit_pre) begin
      rso_q  <= 1'b0;
      en_q   <= 1'b1;
      data_q <= '0;
      last_q <= 1'b0;
    end else if (cmd_i.emit_snap) begin
      rso_q  <= rs_q;
      en_q   <= !step_q[0];
      data_q <= cur_data;
      last_q <= final_now;
    end
  end

  assign sts_o.cnt_one   = (cnt_q == HoldW'(1));
  assign sts_o.hold_one  = (hold_m1 == '0);
  assign sts_o.final_now = final_now;
  assign sts_o.done      = done_q;

  assign snap_valid_o = valid_q;
  assign reg_select_o = rso_q;
  assign enable_pin_o = en_q;
  assign data_lines_o = data_q;
  assign last_o       = last_q;

endmodule
`default_nettype wire

/* rtl/char_lcd_bus_write_sequencer.sv */
// character lcd bus write sequencer
// a request is taken on start_i while busy_o is low: opcode_i selects
// init (0), command byte (1) or data byte (2), byte_value_i is the byte;
// opcode 3 is taken and ignored
// each pin snapshot appears for one cycle with snap_valid_o high, last_o
// marks the final one of a request; the bus holds each snapshot for the
// time set by enable_hold_cycles (0 counts as 1) before the next one
// a command or data byte is 4 snapshots in 4-bit mode, 2 in 8-bit mode;
// init is 33 snapshots in 4-bit mode, 15 in 8-bit mode
// a request's length is set by its snapshots and the hold down-counter;
// the first snapshot shows once start has passed the state register and then
// the snapshot register; busy_o drops when the final snapshot's hold has run out
// cfg_we_i writes register cfg_idx_i (0 bus_mode, 1 enable_hold_cycles)
// and must be used only while busy_o is low; the block does not enforce it
// reset selects 4-bit mode and a hold setting of 1000, sequencer idle
// the receiver cannot stall results
`default_nettype none
module char_lcd_bus_write_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  output logic             snap_valid_o,
  output logic             reg_select_o,
  output logic             enable_pin_o,
  output logic [7:0]       data_lines_o,
  output logic             last_o
);
  import chlcd_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  chlcd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  chlcd_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .opcode_i     (opcode_i),
    .byte_value_i (byte_value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sts_o        (sts),
    .snap_valid_o (snap_valid_o),
    .reg_select_o (reg_select_o),
    .enable_pin_o (enable_pin_o),
    .data_lines_o (data_lines_o),
    .last_o       (last_o)
  );

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (opcode_i == OP_INIT || opcode_i == OP_CMD ||
    opcode_i == OP_DATA) |=> busy_o)
    else $error("request taken but sequencer not busy");

  a_snap_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_o |-> $past(busy_o))
    else $error("snapshot without active request");

  a_last_en_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_o && last_o |-> !enable_pin_o)
    else $error("final snapshot with enable high");

endmodule
`default_nettype wire

/* tb/sv/tb_char_lcd_bus_write_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_char_lcd_bus_write_sequencer;
  import chlcd_pkg::*;

  typedef struct packed {
    logic       rs;
    logic       en;
    logic [7:0] data;
    logic       last;
  } lcd_snap_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] b;
  } lcd_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  opcode_i = 2'd0;
  logic [7:0]  byte_value_i = 8'd0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_wdata_i = 16'd0;
  logic        snap_valid_o;
  logic        reg_select_o;
  logic        enable_pin_o;
  logic [7:0]  data_lines_o;
  logic        last_o;

  lcd_req_t    pending_q[$];
  lcd_snap_t   snap_q[$];

  // shadow of the bus mode and hold registers
  logic        lcd_four = 1'b1;
  logic [15:0] hold_cfg = HoldReset;

  int unsigned sender_idle_pct = 0;
  logic        drain_wait = 1'b0;
  logic        rand_drain_en = 1'b0;
  int unsigned fail_cnt = 0;
  int unsigned snaps_checked = 0;
  int unsigned n_init = 0, n_cmd = 0, n_data = 0, n_unused = 0;

  char_lcd_bus_write_sequencer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .opcode_i     (opcode_i),
    .byte_value_i (byte_value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .snap_valid_o (snap_valid_o),
    .reg_select_o (reg_select_o),
    .enable_pin_o (enable_pin_o),
    .data_lines_o (data_lines_o),
    .last_o       (last_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic void push_snap(input logic rs, input logic en, input logic [7:0] d);
    lcd_snap_t s;
    s.rs = rs;
    s.en = en;
    s.data = d;
    s.last = 1'b0;
    snap_q.push_back(s);
  endfunction

  function automatic void push_byte(input logic rs, input logic [7:0] b);
    if (lcd_four) begin
      push_snap(rs, 1'b1, {b[7:4], 4'h0});
      push_snap(rs, 1'b0, {b[7:4], 4'h0});
      push_snap(rs, 1'b1, {b[3:0], 4'h0});
      push_snap(rs, 1'b0, {b[3:0], 4'h0});
    end else begin
      push_snap(rs, 1'b1, b);
      push_snap(rs, 1'b0, b);
    end
  endfunction

  function automatic void predict_bus_snaps(input logic [1:0] op, input logic [7:0] b);
    int unsigned base;
    lcd_snap_t s;
    base = snap_q.size();
    case (op)
      OP_INIT: begin
        push_snap(1'b0, 1'b1, 8'h00);
        push_byte(1'b0, CMD_WAKE);
        push_byte(1'b0, CMD_WAKE);
        push_byte(1'b0, CMD_WAKE);
        if (lcd_four) push_byte(1'b0, CMD_HOME4);
        push_byte(1'b0, lcd_four ? CMD_FSET4 : CMD_FSET8);
        push_byte(1'b0, CMD_CLEAR);
        push_byte(1'b0, CMD_DISP_ON_CURSOR);
        push_byte(1'b0, CMD_ENTRY_INC);
      end
      OP_CMD:  push_byte(1'b0, b);
      OP_DATA: push_byte(1'b1, b);
      default: ;
    endcase
    if (snap_q.size() > base) begin
      s = snap_q[snap_q.size()-1];
      s.last = 1'b1;
      snap_q[snap_q.size()-1] = s;
    end
  endfunction

  // request driver
  always @(posedge clk_i) begin
    lcd_req_t r;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (drain_wait && snap_q.size() == 0) drain_wait = 1'b0;
      if (start_i && !busy_o) begin
        r = pending_q.pop_front();
        predict_bus_snaps(r.op, r.b);
        case (r.op)
          OP_INIT: n_init++;
          OP_CMD:  n_cmd++;
          OP_DATA: n_data++;
          default: n_unused++;
        endcase
        if (rand_drain_en && $urandom_range(99) < 5) drain_wait = 1'b1;
      end
      if (!start_i || !busy_o) begin
        if (pending_q.size() != 0 && !drain_wait &&
            $urandom_range(99) >= sender_idle_pct) begin
          start_i      <= 1'b1;
          opcode_i     <= pending_q[0].op;
          byte_value_i <= pending_q[0].b;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // snapshot monitor
  always @(posedge clk_i) begin
    lcd_snap_t e;
    if (rst_ni && snap_valid_o) begin
      if (snap_q.size() == 0) begin
        $error("unexpected snapshot: rs %0b en %0b data %02h last %0b",
               reg_select_o, enable_pin_o, data_lines_o, last_o);
        fail_cnt++;
      end else begin
        e = snap_q.pop_front();
        snaps_checked++;
        if (reg_select_o !== e.rs) begin
          $error("reg_select: expected %0b, got %0b", e.rs, reg_select_o);
          fail_cnt++;
        end
        if (enable_pin_o !== e.en) begin
          $error("enable_pin: expected %0b, got %0b", e.en, enable_pin_o);
          fail_cnt++;
        end
        if (data_lines_o !== e.data) begin
          $error("data_lines: expected %02h, got %02h", e.data, data_lines_o);
          fail_cnt++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %0b, got %0b", e.last, last_o);
          fail_cnt++;
        end
      end
    end
  end

  task automatic add_req(input logic [1:0] op, input logic [7:0] b);
    lcd_req_t r;
    r.op = op;
    r.b = b;
    pending_q.push_back(r);
  endtask

  task automatic write_cfg(input logic idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BUS_MODE) lcd_four = val[0];
    else hold_cfg = val;
  endtask

  // all requests taken, all snapshots seen, then let the block settle
  task automatic wait_idle();
    int unsigned pause;
    do @(posedge clk_i);
    while (pending_q.size() != 0 || start_i || snap_q.size() != 0);
    pause = int'(hold_cfg) + 8;
    repeat (pause) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic add_random_req();
    logic [1:0] op;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 15) op = OP_INIT;
    else if (sel < 55) op = OP_CMD;
    else if (sel < 95) op = OP_DATA;
    else op = 2'd3;
    add_req(op, 8'($urandom_range(255)));
  endtask

  initial begin
    int unsigned idle_pct[3];
    idle_pct[0] = 26;
    idle_pct[1] = 79;
    idle_pct[2] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 4-bit bus, hold 1000
    sender_idle_pct = 26;
    add_req(OP_INIT, 8'h00);
    add_req(OP_CMD, 8'h00);
    add_req(OP_DATA, 8'hFF);
    wait_idle();

    // 8-bit bus, zero hold
    write_cfg(CFG_BUS_MODE, 16'd0);
    write_cfg(CFG_HOLD, 16'd0);
    add_req(OP_INIT, 8'hFF);
    add_req(OP_CMD, 8'hFF);
    add_req(OP_DATA, 8'h00);
    add_req(2'd3, 8'h5A);
    add_req(OP_DATA, 8'hA5);
    add_req(OP_CMD, 8'h3C);
    wait_idle();

    // longest hold
    write_cfg(CFG_HOLD, 16'hFFFF);
    add_req(OP_DATA, 8'h81);
    wait_idle();

    // 4-bit bus, shortest nonzero hold
    write_cfg(CFG_BUS_MODE, 16'hFFFF);
    write_cfg(CFG_HOLD, 16'd1);
    add_req(OP_INIT, 8'h00);
    add_req(OP_CMD, 8'hA5);
    add_req(OP_DATA, 8'h5A);
    add_req(2'd3, 8'hFF);
    add_req(OP_DATA, 8'h0F);
    add_req(OP_CMD, 8'hF0);
    add_req(2'd3, 8'h00);
    wait_idle();

    rand_drain_en = 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = idle_pct[ph];
      for (int seg = 0; seg < 2; seg++) begin
        write_cfg(CFG_BUS_MODE, 16'($urandom_range(1)));
        if ($urandom_range(9) == 0) write_cfg(CFG_HOLD, 16'($urandom_range(60, 20)));
        else write_cfg(CFG_HOLD, 16'($urandom_range(6)));
        repeat (25) add_random_req();
        wait_idle();
      end
    end

    $display("%0d requests taken: %0d init, %0d command, %0d data, %0d unused opcode",
             n_init + n_cmd + n_data + n_unused, n_init, n_cmd, n_data, n_unused);
    $display("%0d bus snapshots checked over both bus widths and hold times 0 to 65535",
             snaps_checked);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
